// File: rtl/core/bbcm_pkg.sv
// ----------------------------------------------------------------------------
// bbcm_pkg
// Shared types and codes for the block buffer cache manager.
// ----------------------------------------------------------------------------
`default_nettype none

package bbcm_pkg;

    localparam int SLOTS_DEFAULT = 64;

    localparam logic [2:0] CMD_GET        = 3'd0;
    localparam logic [2:0] CMD_RELEASE    = 3'd1;
    localparam logic [2:0] CMD_MARK_VALID = 3'd2;
    localparam logic [2:0] CMD_MARK_DIRTY = 3'd3;
    localparam logic [2:0] CMD_SYNC       = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FREE   = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_HIT,
        S_NOFREE,
        S_RD_HEAD,
        S_MISS,
        S_REL_CHK,
        S_APP1,
        S_APP2,
        S_SIMPLE,
        S_SYNC,
        S_SYNC_END
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_START,
        OP_SCAN,
        OP_HIT,
        OP_NOFREE,
        OP_RD_HEAD,
        OP_MISS,
        OP_RD_SLOT,
        OP_REL,
        OP_APP1,
        OP_APP2,
        OP_SIMPLE,
        OP_SYNC,
        OP_SYNC_END
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic       clr_done;
        logic       match;
        logic       scan_done;
        logic       empty;
        logic       cnt_zero;
        logic       cnt_one;
        logic       oob;
        logic       out_free;
        logic [2:0] cmd;
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/block_buffer_cache_manager.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_manager
// Buffer slot table with tag lookup, reference counts and a linked free list.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. After reset a clearing pass
// initialises the slot tables; in_ready stays low until it ends. A get
// scans the tag table one slot per cycle through its read port, stopping
// at a hit; a miss then reads the head of the free list. Sync walks every
// slot, stalling under output back-pressure, and gives one result per dirty
// slot, or a single result with no writeback if none is dirty.
`default_nettype none

module block_buffer_cache_manager
#(
    parameter int SLOTS = bbcm_pkg::SLOTS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  cmd,
    input  wire logic [15:0] device,
    input  wire logic [31:0] block_number,
    input  wire logic [5:0]  slot,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [5:0]       slot_out,
    output logic             hit,
    output logic             need_read,
    output logic             writeback,
    output logic [15:0]      wb_device,
    output logic [31:0]      wb_block,
    output logic             last
);

    bbcm_pkg::ctrl_t ctrl;
    bbcm_pkg::stat_t stat;

    bbcm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bbcm_dp
    #(
        .SLOTS (SLOTS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .stat         (stat),
        .cmd          (cmd),
        .device       (device),
        .block_number (block_number),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .slot_out     (slot_out),
        .hit          (hit),
        .need_read    (need_read),
        .writeback    (writeback),
        .wb_device    (wb_device),
        .wb_block     (wb_block),
        .last         (last)
    );

endmodule

`default_nettype wire

// File: rtl/core/bbcm_ctrl.sv
// ----------------------------------------------------------------------------
// bbcm_ctrl
// Sequencer: steps each command through datapath micro-operations.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcm_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bbcm_pkg::stat_t stat,
    output bbcm_pkg::ctrl_t      ctrl
);

    bbcm_pkg::state_t state_reg;
    bbcm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbcm_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = bbcm_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            bbcm_pkg::S_CLEAR:
            begin
                ctrl.op = bbcm_pkg::OP_CLEAR;
                if (stat.clr_done)
                begin
                    state_next = bbcm_pkg::S_IDLE;
                end
            end
            bbcm_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.op    = bbcm_pkg::OP_ACCEPT;
                    state_next = bbcm_pkg::S_DECODE;
                end
            end
            bbcm_pkg::S_DECODE:
            begin
                case (stat.cmd)
                    bbcm_pkg::CMD_GET:
                    begin
                        ctrl.op    = bbcm_pkg::OP_START;
                        state_next = bbcm_pkg::S_SCAN;
                    end
                    bbcm_pkg::CMD_SYNC:
                    begin
                        ctrl.op    = bbcm_pkg::OP_START;
                        state_next = bbcm_pkg::S_SYNC;
                    end
                    bbcm_pkg::CMD_RELEASE:
                    begin
                        if (stat.oob)
                        begin
                            state_next = bbcm_pkg::S_SIMPLE;
                        end
                        else
                        begin
                            ctrl.op    = bbcm_pkg::OP_RD_SLOT;
                            state_next = bbcm_pkg::S_REL_CHK;
                        end
                    end
                    default:
                    begin
                        state_next = bbcm_pkg::S_SIMPLE;
                    end
                endcase
            end
            bbcm_pkg::S_SCAN:
            begin
                ctrl.op = bbcm_pkg::OP_SCAN;
                if (stat.match)
                begin
                    state_next = bbcm_pkg::S_HIT;
                end
                else if (stat.scan_done)
                begin
                    state_next = stat.empty ? bbcm_pkg::S_NOFREE : bbcm_pkg::S_RD_HEAD;
                end
            end
            bbcm_pkg::S_HIT:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = bbcm_pkg::OP_HIT;
                    state_next = bbcm_pkg::S_IDLE;
                end
            end
            bbcm_pkg::S_NOFREE:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = bbcm_pkg::OP_NOFREE;
                    state_next = bbcm_pkg::S_IDLE;
                end
            end
            bbcm_pkg::S_RD_HEAD:
            begin
                ctrl.op    = bbcm_pkg::OP_RD_HEAD;
                state_next = bbcm_pkg::S_MISS;
            end
            bbcm_pkg::S_MISS:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = bbcm_pkg::OP_MISS;
                    state_next = bbcm_pkg::S_IDLE;
                end
            end
            bbcm_pkg::S_REL_CHK:
            begin
                if (stat.out_free)
                begin
                    ctrl.op = bbcm_pkg::OP_REL;
                    if (!stat.cnt_zero && stat.cnt_one && !stat.empty)
                    begin
                        state_next = bbcm_pkg::S_APP1;
                    end
                    else
                    begin
                        state_next = bbcm_pkg::S_IDLE;
                    end
                end
            end
            bbcm_pkg::S_APP1:
            begin
                ctrl.op    = bbcm_pkg::OP_APP1;
                state_next = bbcm_pkg::S_APP2;
            end
            bbcm_pkg::S_APP2:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = bbcm_pkg::OP_APP2;
                    state_next = bbcm_pkg::S_IDLE;
                end
            end
            bbcm_pkg::S_SIMPLE:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = bbcm_pkg::OP_SIMPLE;
                    state_next = bbcm_pkg::S_IDLE;
                end
            end
            bbcm_pkg::S_SYNC:
            begin
                ctrl.op = bbcm_pkg::OP_SYNC;
                if (stat.scan_done)
                begin
                    state_next = bbcm_pkg::S_SYNC_END;
                end
            end
            bbcm_pkg::S_SYNC_END:
            begin
                if (stat.out_free)
                begin
                    ctrl.op    = bbcm_pkg::OP_SYNC_END;
                    state_next = bbcm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bbcm_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/bbcm_dp.sv
// ----------------------------------------------------------------------------
// bbcm_dp
// Slot tables, free-list pointers, scan counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcm_dp
#(
    parameter int SLOTS = bbcm_pkg::SLOTS_DEFAULT
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bbcm_pkg::ctrl_t ctrl,
    output bbcm_pkg::stat_t      stat,
    input  wire logic [2:0]      cmd,
    input  wire logic [15:0]     device,
    input  wire logic [31:0]     block_number,
    input  wire logic [5:0]      slot,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [1:0]           status,
    output logic [5:0]           slot_out,
    output logic                 hit,
    output logic                 need_read,
    output logic                 writeback,
    output logic [15:0]          wb_device,
    output logic [31:0]          wb_block,
    output logic                 last
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [15:0]   tagd_mem [SLOTS];
    logic [31:0]   tagb_mem [SLOTS];
    logic          valid_mem [SLOTS];
    logic          dirty_mem [SLOTS];
    logic [7:0]    cnt_mem [SLOTS];
    logic [IW-1:0] nxt_mem [SLOTS];
    logic [IW-1:0] prv_mem [SLOTS];

    logic [2:0]    cmd_reg;
    logic [15:0]   dev_reg;
    logic [31:0]   blk_reg;
    logic [5:0]    slot_reg;

    logic [CW-1:0] idx_reg,  idx_next;
    logic          rdv_reg,  rdv_next;
    logic [IW-1:0] addr_reg;
    logic [15:0]   rd_tagd_reg;
    logic [31:0]   rd_tagb_reg;
    logic          rd_valid_reg;
    logic          rd_dirty_reg;
    logic [7:0]    rd_cnt_reg;
    logic [IW-1:0] rd_nxt_reg;
    logic [IW-1:0] rd_prv_reg;

    logic [IW-1:0] s_reg,    s_next;
    logic [IW-1:0] t_reg,    t_next;
    logic [IW-1:0] head_reg, head_next;
    logic          empty_reg, empty_next;

    logic          pend_v_reg, pend_v_next;
    logic [5:0]    pend_slot_reg;
    logic [15:0]   pend_dev_reg;
    logic [31:0]   pend_blk_reg;
    logic          pend_load;

    logic          out_valid_reg;
    logic [1:0]    status_reg;
    logic [5:0]    slot_out_reg;
    logic          hit_reg;
    logic          need_read_reg;
    logic          writeback_reg;
    logic [15:0]   wb_device_reg;
    logic [31:0]   wb_block_reg;
    logic          last_reg;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          tag_we;
    logic [IW-1:0] tag_wa;
    logic [15:0]   tagd_wd;
    logic [31:0]   tagb_wd;
    logic          valid_we, valid_wd;
    logic [IW-1:0] valid_wa;
    logic          dirty_we, dirty_wd;
    logic [IW-1:0] dirty_wa;
    logic          cnt_we;
    logic [IW-1:0] cnt_wa;
    logic [7:0]    cnt_wd;
    logic          nxt_we;
    logic [IW-1:0] nxt_wa, nxt_wd;
    logic          prv_we;
    logic [IW-1:0] prv_wa, prv_wd;

    logic          emit;
    logic [1:0]    e_status;
    logic [5:0]    e_slot;
    logic          e_hit, e_nr, e_wb, e_last;
    logic [15:0]   e_dev;
    logic [31:0]   e_blk;

    logic          out_free;
    logic          match;
    logic          oob;
    logic          sync_stall;
    logic          dirty_hit;
    logic [IW-1:0] idx_i;
    logic [IW-1:0] slot_i;

    assign out_free  = !out_valid_reg || out_ready;
    assign match     = rdv_reg && (rd_tagd_reg == dev_reg) && (rd_tagb_reg == blk_reg);
    assign oob       = int'(slot_reg) >= SLOTS;
    assign idx_i     = idx_reg[IW-1:0];
    assign slot_i    = IW'(slot_reg);
    assign dirty_hit = rdv_reg && rd_dirty_reg;
    assign sync_stall = dirty_hit && pend_v_reg && !out_free;

    assign stat.clr_done  = (idx_reg == CW'(SLOTS - 1));
    assign stat.match     = match;
    assign stat.scan_done = (idx_reg == CW'(SLOTS)) && !rdv_reg;
    assign stat.empty     = empty_reg;
    assign stat.cnt_zero  = (rd_cnt_reg == 8'd0);
    assign stat.cnt_one   = (rd_cnt_reg == 8'd1);
    assign stat.oob       = oob;
    assign stat.out_free  = out_free;
    assign stat.cmd       = cmd_reg;

    always_comb
    begin
        idx_next    = idx_reg;
        rdv_next    = rdv_reg;
        s_next      = s_reg;
        t_next      = t_reg;
        head_next   = head_reg;
        empty_next  = empty_reg;
        pend_v_next = pend_v_reg;
        pend_load   = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = idx_i;
        tag_we      = 1'b0;
        tag_wa      = s_reg;
        tagd_wd     = dev_reg;
        tagb_wd     = blk_reg;
        valid_we    = 1'b0;
        valid_wa    = s_reg;
        valid_wd    = 1'b0;
        dirty_we    = 1'b0;
        dirty_wa    = s_reg;
        dirty_wd    = 1'b0;
        cnt_we      = 1'b0;
        cnt_wa      = s_reg;
        cnt_wd      = 8'd0;
        nxt_we      = 1'b0;
        nxt_wa      = rd_prv_reg;
        nxt_wd      = rd_nxt_reg;
        prv_we      = 1'b0;
        prv_wa      = rd_nxt_reg;
        prv_wd      = rd_prv_reg;
        emit        = 1'b0;
        e_status    = bbcm_pkg::ST_OK;
        e_slot      = 6'd0;
        e_hit       = 1'b0;
        e_nr        = 1'b0;
        e_wb        = 1'b0;
        e_dev       = 16'd0;
        e_blk       = 32'd0;
        e_last      = 1'b1;

        case (ctrl.op)
            bbcm_pkg::OP_CLEAR:
            begin
                tag_we   = 1'b1;
                tag_wa   = idx_i;
                tagd_wd  = 16'd0;
                tagb_wd  = 32'd0;
                valid_we = 1'b1;
                valid_wa = idx_i;
                dirty_we = 1'b1;
                dirty_wa = idx_i;
                cnt_we   = 1'b1;
                cnt_wa   = idx_i;
                nxt_we   = 1'b1;
                nxt_wa   = idx_i;
                nxt_wd   = (idx_i == IW'(SLOTS - 1)) ? '0 : idx_i + IW'(1);
                prv_we   = 1'b1;
                prv_wa   = idx_i;
                prv_wd   = (idx_i == '0) ? IW'(SLOTS - 1) : idx_i - IW'(1);
                idx_next = idx_reg + CW'(1);
            end
            bbcm_pkg::OP_START:
            begin
                idx_next    = '0;
                rdv_next    = 1'b0;
                pend_v_next = 1'b0;
            end
            bbcm_pkg::OP_SCAN:
            begin
                if (match)
                begin
                    s_next = addr_reg;
                end
                else
                begin
                    rd_en    = (idx_reg != CW'(SLOTS));
                    rdv_next = rd_en;
                    if (rd_en)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            bbcm_pkg::OP_HIT:
            begin
                if (rd_cnt_reg == 8'd0 && !empty_reg)
                begin
                    if (rd_nxt_reg == s_reg)
                    begin
                        empty_next = 1'b1;
                        head_next  = '0;
                    end
                    else
                    begin
                        nxt_we = 1'b1;
                        prv_we = 1'b1;
                        if (head_reg == s_reg)
                        begin
                            head_next = rd_nxt_reg;
                        end
                    end
                end
                cnt_we   = 1'b1;
                cnt_wd   = (rd_cnt_reg == 8'hFF) ? 8'hFF : rd_cnt_reg + 8'd1;
                emit     = 1'b1;
                e_slot   = 6'(s_reg);
                e_hit    = 1'b1;
                e_nr     = !rd_valid_reg;
            end
            bbcm_pkg::OP_NOFREE:
            begin
                emit     = 1'b1;
                e_status = bbcm_pkg::ST_NO_FREE;
            end
            bbcm_pkg::OP_RD_HEAD:
            begin
                rd_en   = 1'b1;
                rd_addr = head_reg;
                s_next  = head_reg;
            end
            bbcm_pkg::OP_MISS:
            begin
                if (rd_nxt_reg == s_reg)
                begin
                    empty_next = 1'b1;
                    head_next  = '0;
                end
                else
                begin
                    nxt_we = 1'b1;
                    prv_we = 1'b1;
                    if (head_reg == s_reg)
                    begin
                        head_next = rd_nxt_reg;
                    end
                end
                cnt_we   = 1'b1;
                cnt_wd   = 8'd1;
                tag_we   = 1'b1;
                valid_we = 1'b1;
                dirty_we = 1'b1;
                emit     = 1'b1;
                e_slot   = 6'(s_reg);
                e_nr     = 1'b1;
                e_wb     = rd_dirty_reg;
                e_dev    = rd_dirty_reg ? rd_tagd_reg : 16'd0;
                e_blk    = rd_dirty_reg ? rd_tagb_reg : 32'd0;
            end
            bbcm_pkg::OP_RD_SLOT:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_i;
                s_next  = slot_i;
            end
            bbcm_pkg::OP_REL:
            begin
                if (rd_cnt_reg == 8'd0)
                begin
                    emit     = 1'b1;
                    e_status = bbcm_pkg::ST_UNDERFLOW;
                    e_slot   = slot_reg;
                end
                else
                begin
                    cnt_we = 1'b1;
                    cnt_wd = rd_cnt_reg - 8'd1;
                    if (rd_cnt_reg != 8'd1)
                    begin
                        emit   = 1'b1;
                        e_slot = slot_reg;
                    end
                    else if (empty_reg)
                    begin
                        head_next  = s_reg;
                        empty_next = 1'b0;
                        nxt_we     = 1'b1;
                        nxt_wa     = s_reg;
                        nxt_wd     = s_reg;
                        prv_we     = 1'b1;
                        prv_wa     = s_reg;
                        prv_wd     = s_reg;
                        emit       = 1'b1;
                        e_slot     = slot_reg;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = head_reg;
                    end
                end
            end
            bbcm_pkg::OP_APP1:
            begin
                t_next = rd_prv_reg;
                nxt_we = 1'b1;
                nxt_wa = s_reg;
                nxt_wd = head_reg;
                prv_we = 1'b1;
                prv_wa = s_reg;
                prv_wd = rd_prv_reg;
            end
            bbcm_pkg::OP_APP2:
            begin
                nxt_we = 1'b1;
                nxt_wa = t_reg;
                nxt_wd = s_reg;
                prv_we = 1'b1;
                prv_wa = head_reg;
                prv_wd = s_reg;
                emit   = 1'b1;
                e_slot = 6'(s_reg);
            end
            bbcm_pkg::OP_SIMPLE:
            begin
                emit = 1'b1;
                case (cmd_reg) inside
                    bbcm_pkg::CMD_RELEASE, bbcm_pkg::CMD_MARK_VALID, bbcm_pkg::CMD_MARK_DIRTY:
                    begin
                        e_slot = slot_reg;
                        if (!oob)
                        begin
                            valid_we = (cmd_reg == bbcm_pkg::CMD_MARK_VALID);
                            valid_wa = slot_i;
                            valid_wd = 1'b1;
                            dirty_we = (cmd_reg == bbcm_pkg::CMD_MARK_DIRTY);
                            dirty_wa = slot_i;
                            dirty_wd = 1'b1;
                        end
                    end
                    default:
                    begin
                        e_slot = 6'd0;
                    end
                endcase
            end
            bbcm_pkg::OP_SYNC:
            begin
                if (!sync_stall)
                begin
                    if (dirty_hit)
                    begin
                        dirty_we    = 1'b1;
                        dirty_wa    = addr_reg;
                        pend_load   = 1'b1;
                        pend_v_next = 1'b1;
                        if (pend_v_reg)
                        begin
                            emit   = 1'b1;
                            e_slot = pend_slot_reg;
                            e_wb   = 1'b1;
                            e_dev  = pend_dev_reg;
                            e_blk  = pend_blk_reg;
                            e_last = 1'b0;
                        end
                    end
                    rd_en    = (idx_reg != CW'(SLOTS));
                    rdv_next = rd_en;
                    if (rd_en)
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            bbcm_pkg::OP_SYNC_END:
            begin
                emit = 1'b1;
                if (pend_v_reg)
                begin
                    e_slot = pend_slot_reg;
                    e_wb   = 1'b1;
                    e_dev  = pend_dev_reg;
                    e_blk  = pend_blk_reg;
                end
                pend_v_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tagd_mem[tag_wa] <= tagd_wd;
            tagb_mem[tag_wa] <= tagb_wd;
        end
        if (valid_we)
        begin
            valid_mem[valid_wa] <= valid_wd;
        end
        if (dirty_we)
        begin
            dirty_mem[dirty_wa] <= dirty_wd;
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            addr_reg     <= rd_addr;
            rd_tagd_reg  <= tagd_mem[rd_addr];
            rd_tagb_reg  <= tagb_mem[rd_addr];
            rd_valid_reg <= valid_mem[rd_addr];
            rd_dirty_reg <= dirty_mem[rd_addr];
            rd_cnt_reg   <= cnt_mem[rd_addr];
            rd_nxt_reg   <= nxt_mem[rd_addr];
            rd_prv_reg   <= prv_mem[rd_addr];
        end
        if (ctrl.op == bbcm_pkg::OP_ACCEPT)
        begin
            cmd_reg  <= cmd;
            dev_reg  <= device;
            blk_reg  <= block_number;
            slot_reg <= slot;
        end
        if (pend_load)
        begin
            pend_slot_reg <= 6'(addr_reg);
            pend_dev_reg  <= rd_tagd_reg;
            pend_blk_reg  <= rd_tagb_reg;
        end
        if (emit)
        begin
            status_reg    <= e_status;
            slot_out_reg  <= e_slot;
            hit_reg       <= e_hit;
            need_read_reg <= e_nr;
            writeback_reg <= e_wb;
            wb_device_reg <= e_dev;
            wb_block_reg  <= e_blk;
            last_reg      <= e_last;
        end
        s_reg <= s_next;
        t_reg <= t_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            rdv_reg       <= 1'b0;
            head_reg      <= '0;
            empty_reg     <= 1'b0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            rdv_reg       <= rdv_next;
            head_reg      <= head_next;
            empty_reg     <= empty_next;
            pend_v_reg    <= pend_v_next;
            out_valid_reg <= emit || (out_valid_reg && !out_ready);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot_out  = slot_out_reg;
    assign hit       = hit_reg;
    assign need_read = need_read_reg;
    assign writeback = writeback_reg;
    assign wb_device = wb_device_reg;
    assign wb_block  = wb_block_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
